// File: sv/bpfa_pkg.sv
// Shared types, constants and a helper function of the bitmap page frame allocator.
package bpfa_pkg;

  // Frame map geometry
  localparam int FRAMES  = 4096;
  localparam int WORD_W  = 64;
  localparam int WORDS   = FRAMES / WORD_W;
  localparam int WIDX_W  = $clog2(WORDS);
  localparam int BIT_W   = $clog2(WORD_W);
  localparam int FRAME_W = WIDX_W + BIT_W;
  localparam int CNT_W   = FRAME_W + 1;

  // Request actions
  localparam logic [1:0] ACT_INIT  = 2'd0;
  localparam logic [1:0] ACT_ALLOC = 2'd1;
  localparam logic [1:0] ACT_FREE  = 2'd2;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_FIRST = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_USABLE_END   = 1'b1;

  localparam logic [CNT_W-1:0] USABLE_FIRST_RST = 13'd0;
  localparam logic [CNT_W-1:0] USABLE_END_RST   = 13'd4096;

  typedef struct packed {
    logic [1:0]         action;
    logic [CNT_W-1:0]   run_length;
    logic [FRAME_W-1:0] start_frame;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [FRAME_W-1:0] granted_frame;
    logic [CNT_W-1:0]   frames_free;
  } rsp_t;

  typedef struct packed {
    logic              en;
    logic [WIDX_W-1:0] addr;
    logic [WORD_W-1:0] data;
  } mem_wr_t;

  // Bits of word w whose frame number lies in [lo, hi)
  function automatic logic [WORD_W-1:0] range_mask(input logic [WIDX_W-1:0] w,
                                                   input logic [CNT_W-1:0]  lo,
                                                   input logic [CNT_W-1:0]  hi);
    logic [WORD_W-1:0] m;
    logic [CNT_W-1:0]  f;
    m = '0;
    for (int b = 0; b < WORD_W; b++) begin
      f = {1'b0, w, BIT_W'(b)};
      m[b] = (f >= lo) && (f < hi);
    end
    return m;
  endfunction

endpackage

// File: sv/bpfa_bitmap_mem.sv
// Frame used-bit memory: one word of frames per row, registered read, row valid bits.
module bpfa_bitmap_mem (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [bpfa_pkg::WIDX_W-1:0] rd_addr,
  output logic [bpfa_pkg::WORD_W-1:0] rd_data,
  input  bpfa_pkg::mem_wr_t           wr
);
  import bpfa_pkg::*;

  logic [WORD_W-1:0] mem_r [WORDS];
  logic [WORD_W-1:0] rd_q_r;
  logic [WORDS-1:0]  row_vld_r;
  logic              rd_vld_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem_r[wr.addr] <= wr.data;
    end
    rd_q_r <= mem_r[rd_addr];
  end

  // Track rows written since reset; an unwritten row reads as all used
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (wr.en) begin
        row_vld_r[wr.addr] <= 1'b1;
      end
      rd_vld_r <= row_vld_r[rd_addr];
    end
  end

  assign rd_data = rd_vld_r ? rd_q_r : '1;

endmodule

// File: sv/bpfa_word_scan.sv
// Free-run search over one bitmap word with the run carried in from lower words.
module bpfa_word_scan (
  input  logic [bpfa_pkg::WORD_W-1:0] used,
  input  logic [bpfa_pkg::CNT_W-1:0]  carry_in,
  input  logic [bpfa_pkg::CNT_W-1:0]  len,
  output logic [bpfa_pkg::WORD_W-1:0] hit,
  output logic [bpfa_pkg::CNT_W-1:0]  carry_out
);
  import bpfa_pkg::*;

  localparam int RUN_W = CNT_W + 1;

  // q[b]: one plus the highest used bit at or below b, zero when none
  logic [BIT_W:0] q [WORD_W];
  logic [RUN_W-1:0] run;

  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      q[b] = used[b] ? (BIT_W+1)'(b + 1) : '0;
    end
    // Prefix propagation, one level per power of two
    for (int k = 0; k < BIT_W; k++) begin
      for (int b = WORD_W - 1; b >= (1 << k); b--) begin
        if (q[b] == '0) begin
          q[b] = q[b - (1 << k)];
        end
      end
    end
    // Run length ending at each bit, compared against the request
    hit = '0;
    for (int b = 0; b < WORD_W; b++) begin
      if (q[b] == '0) begin
        run = {1'b0, carry_in} + RUN_W'(b + 1);
      end else begin
        run = RUN_W'(b + 1) - RUN_W'(q[b]);
      end
      hit[b] = (run >= {1'b0, len});
    end
    // Free run reaching the top of this word
    if (q[WORD_W-1] == '0) begin
      carry_out = carry_in + CNT_W'(WORD_W);
    end else begin
      carry_out = CNT_W'(WORD_W) - CNT_W'(q[WORD_W-1]);
    end
  end

endmodule

// File: sv/bpfa_ctrl.sv
// Request sequencer: init sweep, first-fit search and read-modify-write range passes.
module bpfa_ctrl (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  bpfa_pkg::req_t              in_req,
  input  logic [bpfa_pkg::CNT_W-1:0]  usable_first,
  input  logic [bpfa_pkg::CNT_W-1:0]  usable_end,
  input  logic                        rsp_free,
  output logic                        rsp_valid,
  output bpfa_pkg::rsp_t              rsp,
  output logic [bpfa_pkg::WIDX_W-1:0] rd_addr,
  input  logic [bpfa_pkg::WORD_W-1:0] rd_data,
  output bpfa_pkg::mem_wr_t           mem_wr
);
  import bpfa_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INIT = 5'b00010,
    ST_SRCH = 5'b00100,
    ST_PASS = 5'b01000,
    ST_RESP = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [WIDX_W-1:0]  rd_w_r, rd_w_nxt;
  logic [WIDX_W-1:0]  wr_w_r, wr_w_nxt;
  logic [WIDX_W-1:0]  last_w_r, last_w_nxt;
  logic               issue_r, issue_nxt;
  logic               pend_r, pend_nxt;
  logic               pass_set_r, pass_set_nxt;
  logic [CNT_W-1:0]   rlo_r, rlo_nxt;
  logic [CNT_W-1:0]   rhi_r, rhi_nxt;
  logic [CNT_W-1:0]   len_r, len_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   carry_r, carry_nxt;
  logic [WORD_W-1:0]  hit_r, hit_nxt;
  logic [WIDX_W-1:0]  hit_w_r, hit_w_nxt;
  logic               hit_v_r, hit_v_nxt;
  logic               ok_r, ok_nxt;
  logic [FRAME_W-1:0] gr_r, gr_nxt;

  logic [WORD_W-1:0]  scan_hit;
  logic [CNT_W-1:0]   scan_carry;
  logic [CNT_W-1:0]   init_hi, init_cnt;
  logic [CNT_W:0]     free_sum;
  logic [CNT_W-1:0]   free_hi, free_last;
  logic [BIT_W-1:0]   hit_bit;
  logic [CNT_W-1:0]   g_start, g_hi, g_last;
  logic [WORD_W-1:0]  pass_mask;

  // Lowest set bit of a hit vector
  function automatic logic [BIT_W-1:0] lowest_set(input logic [WORD_W-1:0] v);
    logic [BIT_W-1:0] idx;
    idx = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (v[b]) begin
        idx = BIT_W'(b);
      end
    end
    return idx;
  endfunction

  bpfa_word_scan u_scan (
    .used      (rd_data),
    .carry_in  (carry_r),
    .len       (len_r),
    .hit       (scan_hit),
    .carry_out (scan_carry)
  );

  // Init bounds, clamped to the map
  assign init_hi  = (usable_end > CNT_W'(FRAMES)) ? CNT_W'(FRAMES) : usable_end;
  assign init_cnt = (usable_first < init_hi) ? (init_hi - usable_first) : '0;

  // Free bounds, clamped to the map
  assign free_sum  = {2'b00, in_req.start_frame} + {1'b0, in_req.run_length};
  assign free_hi   = (free_sum > (CNT_W+1)'(FRAMES)) ? CNT_W'(FRAMES) : free_sum[CNT_W-1:0];
  assign free_last = free_hi - CNT_W'(1);

  // Granted run from the registered hit
  assign hit_bit = lowest_set(hit_r);
  assign g_start = {1'b0, hit_w_r, hit_bit} + CNT_W'(1) - len_r;
  assign g_hi    = g_start + len_r;
  assign g_last  = g_hi - CNT_W'(1);

  assign pass_mask = range_mask(wr_w_r, rlo_r, rhi_r);

  assign in_stall = (state_r != ST_IDLE);
  assign rsp      = '{ok: ok_r, granted_frame: gr_r, frames_free: count_r};

  always_comb begin
    state_nxt    = state_r;
    rd_w_nxt     = rd_w_r;
    wr_w_nxt     = wr_w_r;
    last_w_nxt   = last_w_r;
    issue_nxt    = issue_r;
    pend_nxt     = pend_r;
    pass_set_nxt = pass_set_r;
    rlo_nxt      = rlo_r;
    rhi_nxt      = rhi_r;
    len_nxt      = len_r;
    count_nxt    = count_r;
    carry_nxt    = carry_r;
    hit_nxt      = hit_r;
    hit_w_nxt    = hit_w_r;
    hit_v_nxt    = hit_v_r;
    ok_nxt       = ok_r;
    gr_nxt       = gr_r;
    rd_addr      = rd_w_r;
    mem_wr       = '0;
    rsp_valid    = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          gr_nxt = '0;
          case (in_req.action)
            ACT_INIT: begin
              rlo_nxt   = usable_first;
              rhi_nxt   = init_hi;
              count_nxt = init_cnt;
              rd_w_nxt  = '0;
              ok_nxt    = 1'b1;
              state_nxt = ST_INIT;
            end
            ACT_ALLOC: begin
              len_nxt = in_req.run_length;
              if (in_req.run_length == '0 || in_req.run_length > count_r) begin
                ok_nxt    = 1'b0;
                state_nxt = ST_RESP;
              end else begin
                rd_w_nxt   = '0;
                last_w_nxt = '1;
                issue_nxt  = 1'b1;
                pend_nxt   = 1'b0;
                hit_v_nxt  = 1'b0;
                carry_nxt  = '0;
                state_nxt  = ST_SRCH;
              end
            end
            ACT_FREE: begin
              ok_nxt = 1'b1;
              if (in_req.run_length == '0) begin
                state_nxt = ST_RESP;
              end else begin
                rlo_nxt      = {1'b0, in_req.start_frame};
                rhi_nxt      = free_hi;
                rd_w_nxt     = in_req.start_frame[FRAME_W-1:BIT_W];
                last_w_nxt   = free_last[FRAME_W-1:BIT_W];
                issue_nxt    = 1'b1;
                pend_nxt     = 1'b0;
                pass_set_nxt = 1'b0;
                state_nxt    = ST_PASS;
              end
            end
            default: begin
              ok_nxt    = 1'b0;
              state_nxt = ST_RESP;
            end
          endcase
        end
      end

      // Write every word: used everywhere but the usable range
      ST_INIT: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = rd_w_r;
        mem_wr.data = ~range_mask(rd_w_r, rlo_r, rhi_r);
        rd_w_nxt    = rd_w_r + WIDX_W'(1);
        if (rd_w_r == WIDX_W'(WORDS - 1)) begin
          state_nxt = ST_RESP;
        end
      end

      // Stream words through the scan; decide on the registered scan result
      ST_SRCH: begin
        if (issue_r) begin
          rd_w_nxt = rd_w_r + WIDX_W'(1);
          if (rd_w_r == last_w_r) begin
            issue_nxt = 1'b0;
          end
        end
        pend_nxt  = issue_r;
        wr_w_nxt  = rd_w_r;
        hit_v_nxt = pend_r;
        if (pend_r) begin
          hit_nxt   = scan_hit;
          hit_w_nxt = wr_w_r;
          carry_nxt = scan_carry;
        end
        if (hit_v_r) begin
          if (|hit_r) begin
            // Found: claim the run with a set pass
            rlo_nxt      = g_start;
            rhi_nxt      = g_hi;
            rd_w_nxt     = g_start[FRAME_W-1:BIT_W];
            last_w_nxt   = g_last[FRAME_W-1:BIT_W];
            issue_nxt    = 1'b1;
            pend_nxt     = 1'b0;
            pass_set_nxt = 1'b1;
            count_nxt    = count_r - len_r;
            gr_nxt       = g_start[FRAME_W-1:0];
            ok_nxt       = 1'b1;
            state_nxt    = ST_PASS;
          end else if (hit_w_r == WIDX_W'(WORDS - 1)) begin
            ok_nxt    = 1'b0;
            state_nxt = ST_RESP;
          end
        end
      end

      // Read-modify-write the words of [rlo, rhi): set for alloc, clear for free
      ST_PASS: begin
        if (issue_r) begin
          rd_w_nxt = rd_w_r + WIDX_W'(1);
          if (rd_w_r == last_w_r) begin
            issue_nxt = 1'b0;
          end
        end
        pend_nxt = issue_r;
        wr_w_nxt = rd_w_r;
        if (pend_r) begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = wr_w_r;
          if (pass_set_r) begin
            mem_wr.data = rd_data | pass_mask;
          end else begin
            mem_wr.data = rd_data & ~pass_mask;
            count_nxt   = count_r + CNT_W'($countones(rd_data & pass_mask));
          end
          if (wr_w_r == last_w_r) begin
            issue_nxt = 1'b0;
            pend_nxt  = 1'b0;
            state_nxt = ST_RESP;
          end
        end
      end

      // Hand the result to the output register
      ST_RESP: begin
        if (rsp_free) begin
          rsp_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      issue_r <= 1'b0;
      pend_r  <= 1'b0;
      hit_v_r <= 1'b0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      issue_r <= issue_nxt;
      pend_r  <= pend_nxt;
      hit_v_r <= hit_v_nxt;
      count_r <= count_nxt;
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    rd_w_r     <= rd_w_nxt;
    wr_w_r     <= wr_w_nxt;
    last_w_r   <= last_w_nxt;
    pass_set_r <= pass_set_nxt;
    rlo_r      <= rlo_nxt;
    rhi_r      <= rhi_nxt;
    len_r      <= len_nxt;
    carry_r    <= carry_nxt;
    hit_r      <= hit_nxt;
    hit_w_r    <= hit_w_nxt;
    ok_r       <= ok_nxt;
    gr_r       <= gr_nxt;
  end

endmodule

// File: sv/bitmap_page_frame_allocator_core.sv
// Bitmap first-fit page frame allocator: top level with config registers and result register.
// Init writes every map word once, then hands its result to the output register.
// Alloc searches the map word by word, then claims the run with a read-modify-write
// pass over its words; free runs the same pass to clear the run, or skips it if zero length.
// One request in flight; the next is taken while a result waits in the output reg.
// Reset: every frame reads as used and the free count is zero; no clearing pass is needed.
module bitmap_page_frame_allocator_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  bpfa_pkg::req_t                 in_req,
  output logic                           out_valid,
  input  logic                           out_stall,
  output bpfa_pkg::rsp_t                 out_rsp,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bpfa_pkg::CNT_W-1:0]     cfg_wdata
);
  import bpfa_pkg::*;

  logic [CNT_W-1:0]  usable_first_r, usable_first_nxt;
  logic [CNT_W-1:0]  usable_end_r, usable_end_nxt;
  logic              out_valid_r, out_valid_nxt;
  rsp_t              out_rsp_r, out_rsp_nxt;
  logic              rsp_free;
  logic              rsp_valid;
  rsp_t              rsp;
  logic [WIDX_W-1:0] rd_addr;
  logic [WORD_W-1:0] rd_data;
  mem_wr_t           mem_wr;

  assign cfg_ready = 1'b1;

  // Config register writes
  always_comb begin
    usable_first_nxt = usable_first_r;
    usable_end_nxt   = usable_end_r;
    if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_USABLE_FIRST: usable_first_nxt = cfg_wdata;
        CFG_USABLE_END:   usable_end_nxt   = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Output register: load a new result, drop once taken
  assign rsp_free = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_rsp_nxt   = out_rsp_r;
    if (rsp_valid) begin
      out_valid_nxt = 1'b1;
      out_rsp_nxt   = rsp;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      usable_first_r <= USABLE_FIRST_RST;
      usable_end_r   <= USABLE_END_RST;
      out_valid_r    <= 1'b0;
    end else begin
      usable_first_r <= usable_first_nxt;
      usable_end_r   <= usable_end_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rsp_r <= out_rsp_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  bpfa_bitmap_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (mem_wr)
  );

  bpfa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req       (in_req),
    .usable_first (usable_first_r),
    .usable_end   (usable_end_r),
    .rsp_free     (rsp_free),
    .rsp_valid    (rsp_valid),
    .rsp          (rsp),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .mem_wr       (mem_wr)
  );

endmodule

// File: sv/bpfa_checker.sv
// Port-level checker for the allocator core and its bind.
module bpfa_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input bpfa_pkg::rsp_t out_rsp
);
  import bpfa_pkg::*;

  // A held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("result changed while stalled");

  // A failed request grants frame zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_rsp.ok |-> out_rsp.granted_frame == '0)
    else $error("failed request with nonzero granted frame");

  // The free count never exceeds the map size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_rsp.frames_free <= CNT_W'(FRAMES))
    else $error("free count out of range");

  // One request at a time: an accepted request blocks the next cycle
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second request accepted back to back");

  // A successful result with a nonzero granted frame leaves the map not fully free
  a_grant_fit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.ok && out_rsp.granted_frame != '0 |->
      out_rsp.frames_free < CNT_W'(FRAMES))
    else $error("grant with a fully free map");

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);
